@@ src/spi_nor_command_sequencer_unit_defines.svh @@
// Assertion macros for the sequencer top level.
`ifndef SPI_NOR_COMMAND_SEQUENCER_UNIT_DEFINES_SVH
`define SPI_NOR_COMMAND_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SNOR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SNOR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/snor_seq_pkg.sv @@
package snor_seq_pkg;

    // Flash geometry and run limits
    localparam int PAGE_BYTES = 256;
    localparam int PAGE_W     = $clog2(PAGE_BYTES);
    localparam int MAX_RUN    = 64;
    localparam int LEN_LIMIT  = (MAX_RUN - 1) * PAGE_BYTES;
    localparam int RUN_W      = $clog2(MAX_RUN + 1);

    // Field widths
    localparam int ACT_W   = 2;
    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 14;
    localparam int SEC_W   = 6;
    localparam int OP_W    = 8;
    localparam int AB_W    = 3;
    localparam int ST_W    = 2;
    localparam int FSIZE_W = 27;
    localparam int SBYTE_W = 19;

    // Stream widths
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 80;

    // APB
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register indexes
    localparam logic [1:0] REG_ADDR4    = 2'd0;
    localparam logic [1:0] REG_FSIZE    = 2'd1;
    localparam logic [1:0] REG_SECTOR   = 2'd2;
    localparam logic [1:0] REG_ERR_BITS = 2'd3;

    // Register reset values
    localparam logic [FSIZE_W-1:0] FSIZE_RST  = FSIZE_W'(16777216);
    localparam logic [SBYTE_W-1:0] SECTOR_RST = SBYTE_W'(65536);

    // Request actions
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ERASE = 2'd2;

    // Opcodes
    localparam logic [OP_W-1:0] OP_NONE  = 8'h00;
    localparam logic [OP_W-1:0] OP_WREN  = 8'h06;
    localparam logic [OP_W-1:0] OP_WRDI  = 8'h04;
    localparam logic [OP_W-1:0] OP_PP    = 8'h02;
    localparam logic [OP_W-1:0] OP_4PP   = 8'h12;
    localparam logic [OP_W-1:0] OP_SE    = 8'hD8;
    localparam logic [OP_W-1:0] OP_4SE   = 8'hDC;
    localparam logic [OP_W-1:0] OP_READ  = 8'h03;
    localparam logic [OP_W-1:0] OP_4READ = 8'h13;
    localparam logic [OP_W-1:0] OP_BULK  = 8'h60;
    localparam logic [OP_W-1:0] OP_CLSR  = 8'h30;

    // Address byte counts
    localparam logic [AB_W-1:0] AB_NONE  = 3'd0;
    localparam logic [AB_W-1:0] AB_THREE = 3'd3;
    localparam logic [AB_W-1:0] AB_FOUR  = 3'd4;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // Job kinds handed from front to back
    localparam logic [1:0] JOB_ERR   = 2'd0;
    localparam logic [1:0] JOB_READ  = 2'd1;
    localparam logic [1:0] JOB_WRITE = 2'd2;
    localparam logic [1:0] JOB_ERASE = 2'd3;

    // Job queue
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic               four;
        logic [FSIZE_W-1:0] flash_size;
        logic [SBYTE_W-1:0] sector_bytes;
        logic               err_bits;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ST_W-1:0]   status;
        logic              four;
        logic              clr;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic [SEC_W-1:0]  sectors;
    } job_t;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [ADDR_W-1:0] cmd_address;
        logic [AB_W-1:0]   addr_len;
        logic [LEN_W-1:0]  data_length;
        logic [LEN_W-1:0]  data_offset;
        logic              write_enable_first;
        logic              poll_ready_after;
        logic              write_disable_after;
        logic [ST_W-1:0]   status;
        logic              last;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

@@ src/snor_seq_front.sv @@
module snor_seq_front
(
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // action, address, length, sectors (from bit 0 up), zero fill
    input  logic [snor_seq_pkg::S_DATA_W-1:0] s_tdata,
    input  snor_seq_pkg::cfg_t              cfg,
    input  snor_seq_pkg::q_stat_t           q_stat,
    output logic                            q_push,
    output snor_seq_pkg::job_t              q_job
);
    import snor_seq_pkg::*;

    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic [SEC_W-1:0]  sectors;
    logic [ADDR_W:0]   end_addr;
    logic              past_end;
    logic              too_long;
    logic [RUN_W-1:0]  need;

    // Field unpacking
    assign action  = s_tdata[ACT_W-1:0];
    assign address = s_tdata[ACT_W+ADDR_W-1:ACT_W];
    assign length  = s_tdata[ACT_W+ADDR_W+LEN_W-1:ACT_W+ADDR_W];
    assign sectors = s_tdata[ACT_W+ADDR_W+LEN_W+SEC_W-1:ACT_W+ADDR_W+LEN_W];

    // Accept whenever the queue has room
    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && s_tready;

    // Range checks, end address kept one bit wider so it cannot wrap
    assign end_addr = {1'b0, address} + (ADDR_W+1)'(length);
    assign past_end = end_addr > (ADDR_W+1)'(cfg.flash_size);
    assign too_long = length > LEN_W'(LEN_LIMIT);
    assign need     = RUN_W'(cfg.err_bits)
                    + ((sectors == '0) ? RUN_W'(1) : RUN_W'(sectors));

    // Classify the request
    always_comb
    begin
        q_job         = '0;
        q_job.four    = cfg.four;
        q_job.address = address;
        q_job.length  = length;
        q_job.sectors = sectors;
        q_job.clr     = cfg.err_bits;
        q_job.status  = ST_OK;
        q_job.kind    = JOB_ERR;
        unique case (action)
            ACT_READ:
            begin
                if (too_long)
                    q_job.status = ST_RANGE;
                else
                    q_job.kind = JOB_READ;
            end
            ACT_WRITE:
            begin
                if (length == '0)
                    q_job.status = ST_EMPTY;
                else if (too_long || past_end)
                    q_job.status = ST_RANGE;
                else
                    q_job.kind = JOB_WRITE;
            end
            ACT_ERASE:
            begin
                if (need > RUN_W'(MAX_RUN))
                    q_job.status = ST_RANGE;
                else
                    q_job.kind = JOB_ERASE;
            end
            default:
                q_job.status = ST_RANGE;
        endcase
    end

endmodule

@@ src/snor_seq_fifo.sv @@
module snor_seq_fifo
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  snor_seq_pkg::job_t     push_job,
    input  logic                   pop,
    output snor_seq_pkg::job_t     pop_job,
    output snor_seq_pkg::q_stat_t  stat
);
    import snor_seq_pkg::*;

    job_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign stat.full  = count_reg == (QAW+1)'(QDEPTH);
    assign stat.empty = count_reg == '0;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_job    = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

@@ src/snor_seq_back.sv @@
module snor_seq_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  snor_seq_pkg::cfg_t                cfg,
    input  snor_seq_pkg::q_stat_t             q_stat,
    input  snor_seq_pkg::job_t                q_job,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output snor_seq_pkg::desc_t               out_desc
);
    import snor_seq_pkg::*;

    logic                busy_reg, busy_next;
    logic [1:0]          kind_reg;
    logic [ST_W-1:0]     status_reg;
    logic                four_reg;
    logic                clr_reg, clr_next;
    logic [ADDR_W-1:0]   a_reg, a_next;
    logic [LEN_W-1:0]    left_reg, left_next;
    logic [LEN_W-1:0]    off_reg, off_next;
    logic [SEC_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    desc_t               out_reg;
    desc_t               d;
    logic                fire;
    logic [ADDR_W-1:0]   sent;
    logic [AB_W-1:0]     abytes;
    logic [PAGE_W:0]     room;
    logic [LEN_W-1:0]    piece;

    assign q_pop     = !busy_reg && !q_stat.empty;
    assign fire      = busy_reg && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_desc  = out_reg;

    // Address as sent on the wire and the room left in the current page
    assign sent   = four_reg ? a_reg : {8'h00, a_reg[23:0]};
    assign abytes = four_reg ? AB_FOUR : AB_THREE;
    assign room   = (PAGE_W+1)'(PAGE_BYTES) - {1'b0, a_reg[PAGE_W-1:0]};
    assign piece  = (left_reg < LEN_W'(room)) ? left_reg : LEN_W'(room);

    // Build one descriptor per beat and step the job
    always_comb
    begin
        d         = '0;
        d.status  = ST_OK;
        clr_next  = clr_reg;
        a_next    = a_reg;
        left_next = left_reg;
        off_next  = off_reg;
        cnt_next  = cnt_reg;
        unique case (kind_reg)
            JOB_ERR:
            begin
                d.status = status_reg;
                d.last   = 1'b1;
            end
            JOB_READ:
            begin
                d.opcode      = four_reg ? OP_4READ : OP_READ;
                d.cmd_address = sent;
                d.addr_len    = abytes;
                d.data_length = left_reg;
                d.last        = 1'b1;
            end
            JOB_WRITE:
            begin
                d.opcode              = four_reg ? OP_4PP : OP_PP;
                d.cmd_address         = sent;
                d.addr_len            = abytes;
                d.data_length         = piece;
                d.data_offset         = off_reg;
                d.write_enable_first  = 1'b1;
                d.poll_ready_after    = 1'b1;
                d.write_disable_after = 1'b1;
                d.last                = left_reg == piece;
                a_next                = a_reg + ADDR_W'(piece);
                off_next              = off_reg + piece;
                left_next             = left_reg - piece;
            end
            JOB_ERASE:
            begin
                priority if (clr_reg)
                begin
                    d.opcode = OP_CLSR;
                    clr_next = 1'b0;
                end
                else if (cnt_reg == '0)
                begin
                    d.opcode              = OP_BULK;
                    d.write_enable_first  = 1'b1;
                    d.poll_ready_after    = 1'b1;
                    d.write_disable_after = 1'b1;
                    d.last                = 1'b1;
                end
                else
                begin
                    d.opcode              = four_reg ? OP_4SE : OP_SE;
                    d.cmd_address         = sent;
                    d.addr_len            = abytes;
                    d.write_enable_first  = 1'b1;
                    d.poll_ready_after    = 1'b1;
                    d.write_disable_after = 1'b1;
                    d.last                = cnt_reg == SEC_W'(1);
                    a_next                = a_reg + ADDR_W'(cfg.sector_bytes);
                    cnt_next              = cnt_reg - SEC_W'(1);
                end
            end
        endcase
    end

    // Control next state
    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (q_pop)
            busy_next = 1'b1;
        if (fire)
        begin
            busy_next      = !d.last;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Job registers and output beat
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg   <= q_job.kind;
            status_reg <= q_job.status;
            four_reg   <= q_job.four;
            clr_reg    <= q_job.clr;
            a_reg      <= q_job.address;
            left_reg   <= q_job.length;
            off_reg    <= '0;
            cnt_reg    <= q_job.sectors;
        end
        else if (fire)
        begin
            clr_reg  <= clr_next;
            a_reg    <= a_next;
            left_reg <= left_next;
            off_reg  <= off_next;
            cnt_reg  <= cnt_next;
        end
        if (fire)
            out_reg <= d;
    end

endmodule

@@ src/spi_nor_command_sequencer_unit.sv @@
// SPI NOR command sequencer.
// Slave stream takes one flash request per beat (read, write or erase).
// Master stream returns its run of command descriptors, one per beat, with
// tlast on the final descriptor of each request and the status on tuser.
// The APB port holds the address mode, flash size, sector size and the
// clear-status option; write it only while no request is in flight.
// The first descriptor beat of a request is registered in turn by the job queue,
// the job load from the queue and then the output register.
// Throughput: while busy and while tready is held high, the back end emits one
// descriptor per cycle; a read or an error gives one descriptor, and up to 64 come
// from a 64-page write or a clear-status plus 63-sector erase. A four-entry job
// queue lets requests be accepted while the back end is still busy.
// Reset clears the queue, the back end and the output valid flag and loads
// the register defaults; no memory clearing pass is needed.
// When the receiver holds tready low the output beat stays in place, the back
// end stops, and the slave side keeps accepting until the queue fills.
`include "spi_nor_command_sequencer_unit_defines.svh"

module spi_nor_command_sequencer_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // slave stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // action[1:0], address[33:2], length[47:34], sectors[53:48]
    input  logic [snor_seq_pkg::S_DATA_W-1:0]     s_tdata,
    // master stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // opcode[7:0], cmd_address[39:8], addr_len[42:40], data_length[56:43],
    // data_offset[70:57], write_enable_first[71], poll_ready_after[72],
    // write_disable_after[73]
    output logic [snor_seq_pkg::M_DATA_W-1:0]     m_tdata,
    // status[1:0]
    output logic [snor_seq_pkg::ST_W-1:0]         m_tuser,
    output logic                                  m_tlast,
    // APB configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [snor_seq_pkg::APB_AW-1:0]       paddr,
    input  logic [snor_seq_pkg::APB_DW-1:0]       pwdata,
    output logic [snor_seq_pkg::APB_DW-1:0]       prdata,
    output logic                                  pready
);
    import snor_seq_pkg::*;

    logic               four_reg;
    logic [FSIZE_W-1:0] fsize_reg;
    logic [SBYTE_W-1:0] sector_reg;
    logic               err_bits_reg;
    logic               cfg_wr;
    logic [1:0]         reg_idx;
    cfg_t               cfg;
    q_stat_t            q_stat;
    logic               q_push;
    logic               q_pop;
    job_t               push_job;
    job_t               pop_job;
    desc_t              out_desc;

    // Register file
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_reg     <= 1'b0;
            fsize_reg    <= FSIZE_RST;
            sector_reg   <= SECTOR_RST;
            err_bits_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_ADDR4:    four_reg     <= pwdata[0];
                REG_FSIZE:    fsize_reg    <= pwdata[FSIZE_W-1:0];
                REG_SECTOR:   sector_reg   <= pwdata[SBYTE_W-1:0];
                REG_ERR_BITS: err_bits_reg <= pwdata[0];
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (reg_idx)
            REG_ADDR4:    prdata = APB_DW'(four_reg);
            REG_FSIZE:    prdata = APB_DW'(fsize_reg);
            REG_SECTOR:   prdata = APB_DW'(sector_reg);
            REG_ERR_BITS: prdata = APB_DW'(err_bits_reg);
        endcase
    end

    assign cfg.four         = four_reg;
    assign cfg.flash_size   = fsize_reg;
    assign cfg.sector_bytes = sector_reg;
    assign cfg.err_bits     = err_bits_reg;

    snor_seq_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    snor_seq_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .stat     (q_stat)
    );

    snor_seq_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_stat    (q_stat),
        .q_job     (pop_job),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_desc  (out_desc)
    );

    // Output beat packing
    assign m_tdata = {6'b0, out_desc.write_disable_after, out_desc.poll_ready_after,
                      out_desc.write_enable_first, out_desc.data_offset,
                      out_desc.data_length, out_desc.addr_len,
                      out_desc.cmd_address, out_desc.opcode};
    assign m_tuser = out_desc.status;
    assign m_tlast = out_desc.last;

    // Checks
    `SNOR_ASSERT_NOW(a_err_is_last, clk, rst_n,
        m_tvalid && (m_tuser != ST_OK),
        m_tlast && (out_desc.opcode == OP_NONE), "error beat not a lone final descriptor")
    `SNOR_ASSERT_NOW(a_addr_len, clk, rst_n, m_tvalid,
        (out_desc.addr_len == AB_NONE) || (out_desc.addr_len == AB_THREE)
        || (out_desc.addr_len == AB_FOUR), "bad address byte count")
    `SNOR_ASSERT_NOW(a_three_byte, clk, rst_n, m_tvalid && !four_reg,
        out_desc.cmd_address[ADDR_W-1:24] == '0, "upper address byte sent in 3-byte mode")
    `SNOR_ASSERT_NEXT(a_no_push_full, clk, rst_n, q_stat.full && !q_pop,
        !q_push, "push into a full job queue")

endmodule
